// ===== hw/rtl/grst_pkg.sv =====
// Shared types, constants and helpers for the generational slot table.
`timescale 1ns / 1ps

package grst_pkg;

	// Table geometry
	localparam int SLOT_COUNT = 16;
	localparam int COUNT_BITS = 16;
	localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

	// Fixed field widths of the ports
	localparam int OP_W    = 3;
	localparam int IDX_W   = 4;
	localparam int TAG_W   = 32;
	localparam int GEN_W   = 32;
	localparam int STAT_W  = 3;
	localparam int CNTO_W  = 16;

	// Command queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	typedef enum logic [OP_W-1:0] {
		OP_REGISTER    = 3'd0,
		OP_REGISTER_AT = 3'd1,
		OP_RETAIN      = 3'd2,
		OP_RELEASE     = 3'd3,
		OP_LOOKUP      = 3'd4,
		OP_TRY_UPGRADE = 3'd5,
		OP_QUERY       = 3'd6
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK     = 3'd0,
		ST_NULL   = 3'd1,
		ST_DUP    = 3'd2,
		ST_FULL   = 3'd3,
		ST_INUSE  = 3'd4,
		ST_DEAD   = 3'd5,
		ST_GEN    = 3'd6,
		ST_COUNT  = 3'd7
	} status_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_SCAN,
		BK_EXEC
	} back_state_t;

	// Classified command handed from front to back
	typedef struct packed {
		op_t              op;
		logic [IDX_W-1:0] ix;
		logic [TAG_W-1:0] tag;
		logic [GEN_W-1:0] gen;
		logic             tag_null;
		logic             ix_bad;
	} cmd_t;

	// Low bits of a table index as carried in the result field
	function automatic logic [IDX_W-1:0] slot_field(input logic [SLOT_W-1:0] s);
		logic [63:0] w;
		w = 64'(s);
		return w[IDX_W-1:0];
	endfunction

	// Low bits of a reference count as carried in the result field
	function automatic logic [CNTO_W-1:0] count_field(input logic [COUNT_BITS-1:0] c);
		logic [63:0] w;
		w = 64'(c);
		return w[CNTO_W-1:0];
	endfunction

endpackage

// ===== hw/rtl/grst_front.sv =====
// Front end: accepts input beats, classifies them and hands commands to the queue.
`timescale 1ns / 1ps

module grst_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [grst_pkg::OP_W-1:0]     operation,
	input  logic [grst_pkg::IDX_W-1:0]    slot_index,
	input  logic [grst_pkg::TAG_W-1:0]    owner_tag,
	input  logic [grst_pkg::GEN_W-1:0]    expected_generation,
	output logic                          cmd_valid,
	input  logic                          cmd_ready,
	output grst_pkg::cmd_t                cmd
);

	logic           valid_s1;
	grst_pkg::cmd_t cmd_s1;
	grst_pkg::cmd_t cls;
	logic           accept;
	logic           push;

	// Classify: fold the unused code onto query, flag null tag and out-of-range index
	always_comb begin
		cls.op       = (operation > grst_pkg::OP_W'(grst_pkg::OP_QUERY)) ?
			grst_pkg::OP_QUERY : grst_pkg::op_t'(operation);
		cls.ix       = slot_index;
		cls.tag      = owner_tag;
		cls.gen      = expected_generation;
		cls.tag_null = (owner_tag == '0);
		cls.ix_bad   = (32'(slot_index) >= grst_pkg::SLOT_COUNT);
	end

	assign push     = valid_s1 && cmd_ready;
	assign in_ready = !valid_s1 || cmd_ready;
	assign accept   = in_valid && in_ready;

	// Hold the classified beat until the queue takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cls;
		end
	end

	assign cmd_valid = valid_s1;
	assign cmd       = cmd_s1;

endmodule

// ===== hw/rtl/grst_queue.sv =====
// Short command queue that decouples the front end from the back end.
`timescale 1ns / 1ps

module grst_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  grst_pkg::cmd_t push_cmd,
	output logic           pop_valid,
	input  logic           pop,
	output grst_pkg::cmd_t pop_cmd
);

	grst_pkg::cmd_t                  entry_q [grst_pkg::QUEUE_DEPTH];
	logic [grst_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [grst_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [grst_pkg::QCNT_W-1:0]     fill_q;
	logic                            do_push;
	logic                            do_pop;

	assign push_ready = (32'(fill_q) < grst_pkg::QUEUE_DEPTH);
	assign pop_valid  = (fill_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;
	assign pop_cmd    = entry_q[rd_ptr_q];

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (32'(wr_ptr_q) == grst_pkg::QUEUE_DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (32'(rd_ptr_q) == grst_pkg::QUEUE_DEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	// Store the pushed command
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// ===== hw/rtl/grst_back.sv =====
// Back end: slot stores, register scan, read-modify-write of one slot and result register.
`timescale 1ns / 1ps

module grst_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cmd_valid,
	output logic                            cmd_pop,
	input  grst_pkg::cmd_t                  cmd,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [grst_pkg::STAT_W-1:0]     status,
	output logic [grst_pkg::IDX_W-1:0]      result_slot,
	output logic [grst_pkg::GEN_W-1:0]      slot_generation_out,
	output logic [grst_pkg::CNTO_W-1:0]     slot_count_out,
	output logic [grst_pkg::TAG_W-1:0]      slot_tag_out
);

	// Slot stores
	logic [grst_pkg::TAG_W-1:0]      owner_q [grst_pkg::SLOT_COUNT];
	logic [grst_pkg::GEN_W-1:0]      gen_q   [grst_pkg::SLOT_COUNT];
	logic [grst_pkg::COUNT_BITS-1:0] cnt_q   [grst_pkg::SLOT_COUNT];

	grst_pkg::back_state_t       state_q, state_d;
	grst_pkg::cmd_t              cmd_q;
	logic [grst_pkg::SLOT_W-1:0] scan_q, scan_d;

	logic [grst_pkg::SLOT_W-1:0]     idx;
	logic [grst_pkg::TAG_W-1:0]      own;
	logic [grst_pkg::GEN_W-1:0]      gen;
	logic [grst_pkg::COUNT_BITS-1:0] cnt;
	logic [grst_pkg::TAG_W-1:0]      nxt_own;
	logic [grst_pkg::GEN_W-1:0]      nxt_gen;
	logic [grst_pkg::COUNT_BITS-1:0] nxt_cnt;
	logic                            wr_en;
	logic                            cnt_zero;
	logic                            cnt_sat;

	logic                            res_load;
	grst_pkg::status_t               res_status;
	logic [grst_pkg::IDX_W-1:0]      res_slot;
	logic                            res_present;

	logic                            out_valid_q;
	grst_pkg::status_t               status_q;
	logic [grst_pkg::IDX_W-1:0]      slot_q;
	logic [grst_pkg::GEN_W-1:0]      gen_out_q;
	logic [grst_pkg::CNTO_W-1:0]     cnt_out_q;
	logic [grst_pkg::TAG_W-1:0]      tag_out_q;

	// Read the addressed slot
	always_comb begin
		idx      = (state_q == grst_pkg::BK_SCAN) ? scan_q : grst_pkg::SLOT_W'(cmd_q.ix);
		own      = owner_q[idx];
		gen      = gen_q[idx];
		cnt      = cnt_q[idx];
		cnt_zero = (cnt == '0);
		cnt_sat  = (cnt == grst_pkg::COUNT_MAX);
	end

	// Next state, slot update and result
	always_comb begin
		state_d     = state_q;
		scan_d      = scan_q;
		cmd_pop     = 1'b0;
		nxt_own     = own;
		nxt_gen     = gen;
		nxt_cnt     = cnt;
		wr_en       = 1'b0;
		res_load    = 1'b0;
		res_status  = grst_pkg::ST_OK;
		res_slot    = grst_pkg::slot_field(idx);
		res_present = 1'b1;
		case (state_q)
			grst_pkg::BK_IDLE: begin
				if (cmd_valid && !out_valid_q) begin
					cmd_pop = 1'b1;
					scan_d  = '0;
					state_d = (cmd.op == grst_pkg::OP_REGISTER && !cmd.tag_null) ?
						grst_pkg::BK_SCAN : grst_pkg::BK_EXEC;
				end
			end
			grst_pkg::BK_SCAN: begin
				// Walk slots from index 0: first empty wins, an earlier same-tag slot stops
				if (own == '0) begin
					nxt_own  = cmd_q.tag;
					nxt_gen  = gen + 1'b1;
					nxt_cnt  = grst_pkg::COUNT_BITS'(1);
					wr_en    = 1'b1;
					res_load = 1'b1;
					state_d  = grst_pkg::BK_IDLE;
				end else if (own == cmd_q.tag) begin
					res_status = grst_pkg::ST_DUP;
					res_load   = 1'b1;
					state_d    = grst_pkg::BK_IDLE;
				end else if (32'(scan_q) == grst_pkg::SLOT_COUNT - 1) begin
					res_status  = grst_pkg::ST_FULL;
					res_slot    = '0;
					res_present = 1'b0;
					res_load    = 1'b1;
					state_d     = grst_pkg::BK_IDLE;
				end else begin
					scan_d = scan_q + 1'b1;
				end
			end
			grst_pkg::BK_EXEC: begin
				res_load = 1'b1;
				res_slot = cmd_q.ix;
				state_d  = grst_pkg::BK_IDLE;
				if (cmd_q.op == grst_pkg::OP_REGISTER) begin
					// only a null tag skips the scan
					res_status  = grst_pkg::ST_NULL;
					res_slot    = '0;
					res_present = 1'b0;
				end else if (cmd_q.ix_bad) begin
					res_status  = (cmd_q.op == grst_pkg::OP_REGISTER_AT) ?
						grst_pkg::ST_FULL : grst_pkg::ST_DEAD;
					res_present = 1'b0;
				end else begin
					case (cmd_q.op)
						grst_pkg::OP_REGISTER_AT: begin
							if (cmd_q.tag_null) begin
								res_status  = grst_pkg::ST_NULL;
								res_slot    = '0;
								res_present = 1'b0;
							end else if (own != '0) begin
								res_status = grst_pkg::ST_INUSE;
							end else begin
								nxt_own = cmd_q.tag;
								nxt_gen = gen + 1'b1;
								nxt_cnt = grst_pkg::COUNT_BITS'(1);
								wr_en   = 1'b1;
							end
						end
						grst_pkg::OP_RETAIN: begin
							if (cnt_sat) begin
								res_status = grst_pkg::ST_COUNT;
							end else begin
								nxt_cnt = cnt + 1'b1;
								wr_en   = 1'b1;
							end
						end
						grst_pkg::OP_RELEASE: begin
							if (cnt_zero) begin
								res_status = grst_pkg::ST_COUNT;
							end else begin
								nxt_cnt = cnt - 1'b1;
								if (cnt == grst_pkg::COUNT_BITS'(1)) begin
									nxt_own = '0;
								end
								wr_en = 1'b1;
							end
						end
						grst_pkg::OP_LOOKUP: begin
							if (cnt_zero) begin
								res_status = grst_pkg::ST_DEAD;
							end else if (cnt_sat) begin
								res_status = grst_pkg::ST_COUNT;
							end else begin
								nxt_cnt = cnt + 1'b1;
								wr_en   = 1'b1;
							end
						end
						grst_pkg::OP_TRY_UPGRADE: begin
							if (gen != cmd_q.gen) begin
								res_status = grst_pkg::ST_GEN;
							end else if (cnt_zero) begin
								res_status = grst_pkg::ST_DEAD;
							end else if (cnt_sat) begin
								res_status = grst_pkg::ST_COUNT;
							end else begin
								nxt_cnt = cnt + 1'b1;
								wr_en   = 1'b1;
							end
						end
						default: begin
							res_status = grst_pkg::ST_OK;
						end
					endcase
				end
			end
			default: begin
				state_d = grst_pkg::BK_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= grst_pkg::BK_IDLE;
			scan_q  <= '0;
		end else begin
			state_q <= state_d;
			scan_q  <= scan_d;
		end
	end

	// Latch the popped command
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q <= cmd;
		end
	end

	// Slot stores: clear at reset, write back the updated slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < grst_pkg::SLOT_COUNT; i++) begin
				owner_q[i] <= '0;
				gen_q[i]   <= '0;
				cnt_q[i]   <= '0;
			end
		end else if (wr_en) begin
			owner_q[idx] <= nxt_own;
			gen_q[idx]   <= nxt_gen;
			cnt_q[idx]   <= nxt_cnt;
		end
	end

	// Result register: hold the beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			status_q  <= res_status;
			slot_q    <= res_slot;
			gen_out_q <= res_present ? nxt_gen : '0;
			cnt_out_q <= res_present ? grst_pkg::count_field(nxt_cnt) : '0;
			tag_out_q <= res_present ? nxt_own : '0;
		end
	end

	assign out_valid           = out_valid_q;
	assign status              = status_q;
	assign result_slot         = slot_q;
	assign slot_generation_out = gen_out_q;
	assign slot_count_out      = cnt_out_q;
	assign slot_tag_out        = tag_out_q;

	// A new result never overwrites one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> !out_valid_q)
		else $error("result loaded over a pending result");

	// Only a register with a real tag scans
	a_scan_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == grst_pkg::BK_SCAN |-> cmd_q.op == grst_pkg::OP_REGISTER && !cmd_q.tag_null)
		else $error("scan running for a command that does not scan");

	// A slot written with zero references is left empty
	a_zero_empty: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (nxt_cnt != '0 || nxt_own == '0))
		else $error("slot left owned with no references");

	// The scan index stays inside the table
	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == grst_pkg::BK_SCAN |-> 32'(scan_q) < grst_pkg::SLOT_COUNT)
		else $error("scan index beyond table");

	// After a pop the back end is busy and no result is pending
	a_pop_then_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |=> state_q != grst_pkg::BK_IDLE && !out_valid_q)
		else $error("popped command lost");

endmodule

// ===== hw/rtl/generational_refcounted_slot_table.sv =====
// Top level of the generational, reference-counted slot table.
//
//   channel | handshake            | payload
//   --------+----------------------+------------------------------------------------------
//   in      | in_valid / in_ready  | operation, slot_index, owner_tag, expected_generation
//   out     | out_valid / out_ready| status, result_slot, slot_generation_out,
//           |                      | slot_count_out, slot_tag_out
//
// An item is registered in the front stage, then waits in a two-entry queue.
// The back end takes a command only when its result register is empty, then
// reads, updates and writes back one slot and loads the result register.
// Register scans one slot per cycle from index 0 and stops at the first empty
// slot, at a same-tag slot, or at the last slot of the table.
// Reset clears all slot stores at once; no clearing pass is needed.
// A stalled output holds the back end; the queue and front stage keep accepting until full.
`timescale 1ns / 1ps

module generational_refcounted_slot_table (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [grst_pkg::OP_W-1:0]     operation,
	input  logic [grst_pkg::IDX_W-1:0]    slot_index,
	input  logic [grst_pkg::TAG_W-1:0]    owner_tag,
	input  logic [grst_pkg::GEN_W-1:0]    expected_generation,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [grst_pkg::STAT_W-1:0]   status,
	output logic [grst_pkg::IDX_W-1:0]    result_slot,
	output logic [grst_pkg::GEN_W-1:0]    slot_generation_out,
	output logic [grst_pkg::CNTO_W-1:0]   slot_count_out,
	output logic [grst_pkg::TAG_W-1:0]    slot_tag_out
);

	logic           front_valid;
	logic           front_ready;
	grst_pkg::cmd_t front_cmd;
	logic           q_valid;
	logic           q_pop;
	grst_pkg::cmd_t q_cmd;

	grst_front u_front (
		.clk                 (clk),
		.arst_n              (arst_n),
		.in_valid            (in_valid),
		.in_ready            (in_ready),
		.operation           (operation),
		.slot_index          (slot_index),
		.owner_tag           (owner_tag),
		.expected_generation (expected_generation),
		.cmd_valid           (front_valid),
		.cmd_ready           (front_ready),
		.cmd                 (front_cmd)
	);

	grst_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.push_cmd   (front_cmd),
		.pop_valid  (q_valid),
		.pop        (q_pop),
		.pop_cmd    (q_cmd)
	);

	grst_back u_back (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd_valid           (q_valid),
		.cmd_pop             (q_pop),
		.cmd                 (q_cmd),
		.out_valid           (out_valid),
		.out_ready           (out_ready),
		.status              (status),
		.result_slot         (result_slot),
		.slot_generation_out (slot_generation_out),
		.slot_count_out      (slot_count_out),
		.slot_tag_out        (slot_tag_out)
	);

endmodule
